// ===== hw/rtl/ble_mpp_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_mpp_pkg
// Shared types and constants for the BLE-MIDI packet parser.
// ----------------------------------------------------------------------------
package ble_mpp_pkg;

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_TS      = 3'd1,
        PH_STATUS  = 3'd2,
        PH_CHDATA  = 3'd3,
        PH_SYSDATA = 3'd4
    } t_phase;

    // completed message handed from the front part to the back part
    typedef struct packed {
        logic [7:0]  status;
        logic [6:0]  first;
        logic [6:0]  second;
        logic [12:0] ts;
    } t_cmd;

    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_TIMECODE    = 8'hF1;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_CLOCK       = 8'hF8;
    localparam logic [7:0] ST_START       = 8'hFA;
    localparam logic [7:0] ST_CONTINUE    = 8'hFB;
    localparam logic [7:0] ST_STOP        = 8'hFC;
    localparam logic [7:0] ST_ACT_SENSE   = 8'hFE;
    localparam logic [7:0] ST_RESET       = 8'hFF;

    localparam logic [3:0] CK_NOTE_OFF  = 4'h8;
    localparam logic [3:0] CK_NOTE_ON   = 4'h9;
    localparam logic [3:0] CK_POLY      = 4'hA;
    localparam logic [3:0] CK_CTRL      = 4'hB;
    localparam logic [3:0] CK_PROG      = 4'hC;
    localparam logic [3:0] CK_CHAN_PRES = 4'hD;
    localparam logic [3:0] CK_BEND      = 4'hE;
    localparam logic [3:0] CK_SYSTEM    = 4'hF;

    localparam logic [6:0] CTL_MODE_FIRST = 7'd120;
    localparam logic [6:0] CTL_RESET_ALL  = 7'd121;
    localparam logic [6:0] CTL_LOCAL      = 7'd122;
    localparam logic [6:0] DATA_MAX       = 7'd127;

    localparam logic [4:0] KIND_NOTE_OFF  = 5'd0;
    localparam logic [4:0] KIND_NOTE_ON   = 5'd1;
    localparam logic [4:0] KIND_POLY      = 5'd2;
    localparam logic [4:0] KIND_CTRL      = 5'd3;
    localparam logic [4:0] KIND_MODE_BASE = 5'd4;
    localparam logic [4:0] KIND_LOCAL     = 5'd6;
    localparam logic [4:0] KIND_PROG      = 5'd12;
    localparam logic [4:0] KIND_CHAN_PRES = 5'd13;
    localparam logic [4:0] KIND_BEND      = 5'd14;
    localparam logic [4:0] KIND_TIMECODE  = 5'd15;
    localparam logic [4:0] KIND_SONG_POS  = 5'd16;
    localparam logic [4:0] KIND_SONG_SEL  = 5'd17;
    localparam logic [4:0] KIND_TUNE_REQ  = 5'd18;
    localparam logic [4:0] KIND_CLOCK     = 5'd19;
    localparam logic [4:0] KIND_START     = 5'd20;
    localparam logic [4:0] KIND_CONTINUE  = 5'd21;
    localparam logic [4:0] KIND_STOP      = 5'd22;
    localparam logic [4:0] KIND_ACT_SENSE = 5'd23;
    localparam logic [4:0] KIND_RESET     = 5'd24;

endpackage

// ===== hw/rtl/ble_mpp_front.sv =====
// ----------------------------------------------------------------------------
// ble_mpp_front
// Byte-level packet grammar: header, timestamps, status, running status and
// exclusive skipping. Emits one command per completed message.
// ----------------------------------------------------------------------------
module ble_mpp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic [7:0]        i_data_byte,
    input  logic              i_start_of_packet,
    output logic              o_cmd_vld,
    output ble_mpp_pkg::t_cmd o_cmd
);
    import ble_mpp_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_excl, n_excl;
    logic [5:0]  r_hdr, n_hdr;
    logic [12:0] r_ts, n_ts;
    logic [7:0]  r_rs, n_rs;
    logic        r_rv, n_rv;
    logic [6:0]  r_held, n_held;
    logic        r_hc, n_hc;

    logic [7:0]  b;
    logic [6:0]  v;
    logic        chan_go;
    logic        chan_hc;

    assign b = i_data_byte;
    assign v = i_data_byte[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_excl  <= 1'b0;
            r_hdr   <= '0;
            r_ts    <= '0;
            r_rs    <= '0;
            r_rv    <= 1'b0;
            r_held  <= '0;
            r_hc    <= 1'b0;
        end else if (i_acc) begin
            r_phase <= n_phase;
            r_excl  <= n_excl;
            r_hdr   <= n_hdr;
            r_ts    <= n_ts;
            r_rs    <= n_rs;
            r_rv    <= n_rv;
            r_held  <= n_held;
            r_hc    <= n_hc;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_excl    = r_excl;
        n_hdr     = r_hdr;
        n_ts      = r_ts;
        n_rs      = r_rs;
        n_rv      = r_rv;
        n_held    = r_held;
        n_hc      = r_hc;
        chan_go   = 1'b0;
        chan_hc   = r_hc;
        o_cmd_vld = 1'b0;
        o_cmd     = '{status: r_rs, first: v, second: v, ts: r_ts};

        priority if (i_start_of_packet) begin
            n_rv = 1'b0;
            n_hc = 1'b0;
            if (b[7]) begin
                n_hdr   = b[5:0];
                n_phase = PH_TS;
            end else begin
                n_phase = PH_WAIT;
            end
        end else if (r_phase == PH_WAIT) begin
            n_phase = PH_WAIT;
        end else if (r_excl) begin
            if (b == ST_SYSEX_END) begin
                n_excl  = 1'b0;
                n_phase = PH_TS;
            end else if (b[7]) begin
                n_ts = {r_hdr, v};
            end
        end else begin
            unique case (r_phase)
                PH_TS: begin
                    if (!b[7]) begin
                        n_phase = PH_WAIT;
                    end else begin
                        n_ts    = {r_hdr, v};
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (b[7]) begin
                        n_hc = 1'b0;
                        if (b[7:4] != CK_SYSTEM) begin
                            n_rs    = b;
                            n_rv    = 1'b1;
                            n_phase = PH_CHDATA;
                        end else begin
                            n_phase = PH_TS;
                            if (!b[3]) begin
                                n_rv = 1'b0;
                                if (b == ST_SYSEX_START) begin
                                    n_excl = 1'b1;
                                end else if (b == ST_TIMECODE || b == ST_SONG_POS ||
                                             b == ST_SONG_SEL) begin
                                    n_rs    = b;
                                    n_phase = PH_SYSDATA;
                                end else if (b == ST_TUNE_REQ) begin
                                    o_cmd_vld    = 1'b1;
                                    o_cmd.status = b;
                                end
                            end else begin
                                o_cmd_vld    = 1'b1;
                                o_cmd.status = b;
                            end
                        end
                    end else if (!r_rv) begin
                        n_phase = PH_WAIT;
                    end else begin
                        n_phase = PH_CHDATA;
                        chan_go = 1'b1;
                        chan_hc = 1'b0;
                    end
                end
                PH_CHDATA: begin
                    if (!r_hc && b[7]) begin
                        n_ts    = {r_hdr, v};
                        n_phase = PH_STATUS;
                    end else begin
                        chan_go = 1'b1;
                    end
                end
                PH_SYSDATA: begin
                    if (r_rs == ST_SONG_POS && !r_hc) begin
                        n_held = v;
                        n_hc   = 1'b1;
                    end else begin
                        n_hc        = 1'b0;
                        n_phase     = PH_TS;
                        o_cmd_vld   = 1'b1;
                        if (r_rs == ST_SONG_POS) begin
                            o_cmd.first = r_held;
                        end
                    end
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
        end

        // channel data byte: one-byte messages complete at once, others hold
        if (chan_go) begin
            if (!chan_hc) begin
                if (r_rs[7:4] == CK_PROG || r_rs[7:4] == CK_CHAN_PRES) begin
                    n_hc      = 1'b0;
                    o_cmd_vld = 1'b1;
                end else begin
                    n_held = v;
                    n_hc   = 1'b1;
                end
            end else begin
                n_hc        = 1'b0;
                o_cmd_vld   = 1'b1;
                o_cmd.first = r_held;
            end
        end
    end

endmodule

// ===== hw/rtl/ble_mpp_queue.sv =====
// ----------------------------------------------------------------------------
// ble_mpp_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ble_mpp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  ble_mpp_pkg::t_cmd          i_data,
    input  logic                       i_pop,
    output ble_mpp_pkg::t_cmd          o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);
    import ble_mpp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_level = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/ble_mpp_back.sv =====
// ----------------------------------------------------------------------------
// ble_mpp_back
// Decodes queued commands into events, drops non-events and holds the
// oldest event in an output register.
// ----------------------------------------------------------------------------
module ble_mpp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ble_mpp_pkg::t_cmd i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [4:0]        o_event_kind,
    output logic [3:0]        o_channel,
    output logic [12:0]       o_timestamp,
    output logic [6:0]        o_data_first,
    output logic [6:0]        o_data_second,
    output logic [13:0]       o_wide_value
);
    import ble_mpp_pkg::*;

    logic        r_vld;
    logic [4:0]  r_kind;
    logic [3:0]  r_ch;
    logic [12:0] r_ts;
    logic [6:0]  r_d1;
    logic [6:0]  r_d2;
    logic [13:0] r_wide;

    logic        ev_ok;
    logic [4:0]  ev_kind;
    logic [3:0]  ev_ch;
    logic [6:0]  ev_d1;
    logic [6:0]  ev_d2;
    logic [13:0] ev_wide;
    logic [6:0]  f;
    logic [6:0]  s;
    logic        load;

    assign f = i_cmd.first;
    assign s = i_cmd.second;

    always_comb begin
        ev_ok   = 1'b1;
        ev_kind = KIND_NOTE_OFF;
        ev_ch   = i_cmd.status[3:0];
        ev_d1   = '0;
        ev_d2   = '0;
        ev_wide = '0;
        unique case (i_cmd.status[7:4])
            CK_NOTE_OFF: begin
                ev_d1 = f;
                ev_d2 = s;
            end
            CK_NOTE_ON: begin
                ev_kind = (s == '0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                ev_d1   = f;
                ev_d2   = s;
            end
            CK_POLY: begin
                ev_kind = KIND_POLY;
                ev_d1   = f;
                ev_d2   = s;
            end
            CK_CTRL: begin
                ev_d1 = f;
                priority if (f < CTL_MODE_FIRST) begin
                    ev_kind = KIND_CTRL;
                    ev_d2   = s;
                end else if (f == CTL_RESET_ALL) begin
                    ev_kind = KIND_MODE_BASE + 5'(f[2:0]);
                    ev_d2   = s;
                end else if (f == CTL_LOCAL) begin
                    ev_kind = KIND_LOCAL;
                    ev_d2   = (s == DATA_MAX) ? 7'd1 : 7'd0;
                    ev_ok   = (s == '0) || (s == DATA_MAX);
                end else begin
                    ev_kind = KIND_MODE_BASE + 5'(f[2:0]);
                    ev_ok   = (s == '0);
                end
            end
            CK_PROG: begin
                ev_kind = KIND_PROG;
                ev_d1   = s;
            end
            CK_CHAN_PRES: begin
                ev_kind = KIND_CHAN_PRES;
                ev_d2   = s;
            end
            CK_BEND: begin
                ev_kind = KIND_BEND;
                ev_wide = {s, f};
            end
            CK_SYSTEM: begin
                ev_ch = '0;
                unique case (i_cmd.status)
                    ST_TIMECODE: begin
                        ev_kind = KIND_TIMECODE;
                        ev_d1   = {4'd0, s[6:4]};
                        ev_d2   = {3'd0, s[3:0]};
                    end
                    ST_SONG_POS: begin
                        ev_kind = KIND_SONG_POS;
                        ev_wide = {s, f};
                    end
                    ST_SONG_SEL: begin
                        ev_kind = KIND_SONG_SEL;
                        ev_d1   = s;
                    end
                    ST_TUNE_REQ:  ev_kind = KIND_TUNE_REQ;
                    ST_CLOCK:     ev_kind = KIND_CLOCK;
                    ST_START:     ev_kind = KIND_START;
                    ST_CONTINUE:  ev_kind = KIND_CONTINUE;
                    ST_STOP:      ev_kind = KIND_STOP;
                    ST_ACT_SENSE: ev_kind = KIND_ACT_SENSE;
                    ST_RESET:     ev_kind = KIND_RESET;
                    default:      ev_ok   = 1'b0;
                endcase
            end
            default: begin
                ev_ok = 1'b0;
            end
        endcase
    end

    // non-events are dropped even while the output register is occupied
    assign o_cmd_pop = !i_cmd_empty && (!ev_ok || !r_vld || i_pop);
    assign load      = o_cmd_pop && ev_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (i_pop) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= ev_kind;
            r_ch   <= ev_ch;
            r_ts   <= i_cmd.ts;
            r_d1   <= ev_d1;
            r_d2   <= ev_d2;
            r_wide <= ev_wide;
        end
    end

    assign o_empty       = !r_vld;
    assign o_event_kind  = r_kind;
    assign o_channel     = r_ch;
    assign o_timestamp   = r_ts;
    assign o_data_first  = r_d1;
    assign o_data_second = r_d2;
    assign o_wide_value  = r_wide;

endmodule

// ===== hw/rtl/ble_midi_packet_parser_core.sv =====
// ----------------------------------------------------------------------------
// ble_midi_packet_parser_core
// BLE-MIDI packet parser: one packet byte in, decoded MIDI events out.
// ----------------------------------------------------------------------------
// Takes one packet byte per clock while full is low and delivers at most one
// event per byte, oldest first, while empty is low. A byte that completes a
// message is written into the command queue and decoded from there into the
// output register once that register is free or being popped; its event then
// stays on the result ports until it is popped. Sustained rate is one byte
// per cycle while full is low; full rises only when QUEUE_DEPTH commands wait
// behind a stalled result. No clearing pass is needed after reset.
module ble_midi_packet_parser_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_packet,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_event_kind,
    output logic [3:0]  o_channel,
    output logic [12:0] o_timestamp,
    output logic [6:0]  o_data_first,
    output logic [6:0]  o_data_second,
    output logic [13:0] o_wide_value
);
    import ble_mpp_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          w_acc;
    logic          w_cmd_vld;
    t_cmd          w_cmd;
    t_cmd          w_q_data;
    logic          w_q_empty;
    logic          w_q_pop;
    logic [CW-1:0] w_q_level;

    assign w_acc = push && !full;

    ble_mpp_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_acc             (w_acc),
        .i_data_byte       (i_data_byte),
        .i_start_of_packet (i_start_of_packet),
        .o_cmd_vld         (w_cmd_vld),
        .o_cmd             (w_cmd)
    );

    ble_mpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc && w_cmd_vld),
        .i_data  (w_cmd),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_full  (full),
        .o_empty (w_q_empty),
        .o_level (w_q_level)
    );

    ble_mpp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_q_data),
        .i_cmd_empty   (w_q_empty),
        .o_cmd_pop     (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_event_kind  (o_event_kind),
        .o_channel     (o_channel),
        .o_timestamp   (o_timestamp),
        .o_data_first  (o_data_first),
        .o_data_second (o_data_second),
        .o_wide_value  (o_wide_value)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_level <= CW'(QUEUE_DEPTH))
        else $error("command queue level beyond depth");

    a_sys_no_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_kind >= KIND_TIMECODE) |-> (o_channel == '0))
        else $error("system event with non-zero channel");

    a_local_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_kind == KIND_LOCAL) |-> (o_data_second <= 7'd1))
        else $error("local control flag out of range");

    a_bend_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_kind == KIND_BEND) |->
        (o_data_first == '0 && o_data_second == '0))
        else $error("pitch bend with non-zero data fields");

endmodule

// ===== test/tb_ble_midi_packet_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ble_midi_packet_parser_core
// Drives BLE-MIDI packet bytes into the parser and checks every event against
// a cycle-free behavioural predictor. A short table of directed bytes comes
// first, then random packets built mostly from well-formed messages with some
// noise, cut messages and open exclusive blocks. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_ble_midi_packet_parser_core;
    import ble_mpp_pkg::*;

    localparam int ITEMS      = 1250;
    localparam int PRINT_CAP  = 50;

    typedef struct packed {
        logic [4:0]  kind;
        logic [3:0]  chan;
        logic [12:0] ts;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [13:0] wide;
    } t_midi_event;

    typedef struct packed {
        logic        sop;
        logic [7:0]  b;
        logic        typed;
        t_midi_event ev;
    } t_stim_row;

    typedef struct packed {
        logic       sop;
        logic [7:0] b;
    } t_link_byte;

    localparam t_midi_event NO_EV = '0;

    localparam t_stim_row DIR_TAB [46] = '{
        '{1'b1, 8'h80, 1'b0, NO_EV},
        '{1'b0, 8'h80, 1'b0, NO_EV},
        '{1'b0, 8'h9F, 1'b0, NO_EV},
        '{1'b0, 8'h7F, 1'b0, NO_EV},
        '{1'b0, 8'h7F, 1'b1, '{KIND_NOTE_ON, 4'hF, 13'd0, DATA_MAX, DATA_MAX, 14'd0}},
        '{1'b0, 8'h00, 1'b0, NO_EV},
        '{1'b0, 8'h80, 1'b1, '{KIND_NOTE_OFF, 4'hF, 13'd0, 7'd0, 7'd0, 14'd0}},
        '{1'b0, 8'hFF, 1'b0, NO_EV},
        '{1'b0, 8'hF8, 1'b1, '{KIND_CLOCK, 4'h0, 13'd127, 7'd0, 7'd0, 14'd0}},
        '{1'b0, 8'h85, 1'b0, NO_EV},
        '{1'b0, 8'h10, 1'b0, NO_EV},
        '{1'b0, 8'h00, 1'b0, NO_EV},
        '{1'b1, 8'hBF, 1'b0, NO_EV},
        '{1'b0, 8'hFF, 1'b0, NO_EV},
        '{1'b0, 8'hF2, 1'b0, NO_EV},
        '{1'b0, 8'hFF, 1'b0, NO_EV},
        '{1'b0, 8'hFF, 1'b1, '{KIND_SONG_POS, 4'h0, 13'd8191, 7'd0, 7'd0, 14'h3FFF}},
        '{1'b0, 8'h80, 1'b0, NO_EV},
        '{1'b0, 8'hF0, 1'b0, NO_EV},
        '{1'b1, 8'h90, 1'b0, NO_EV},
        '{1'b0, 8'h81, 1'b0, NO_EV},
        '{1'b0, 8'h45, 1'b0, NO_EV},
        '{1'b0, 8'hF7, 1'b0, NO_EV},
        '{1'b0, 8'h82, 1'b0, NO_EV},
        '{1'b0, 8'hF4, 1'b0, NO_EV},
        '{1'b0, 8'h83, 1'b0, NO_EV},
        '{1'b0, 8'h12, 1'b0, NO_EV},
        '{1'b0, 8'h55, 1'b0, NO_EV},
        '{1'b1, 8'h00, 1'b0, NO_EV},
        '{1'b0, 8'h80, 1'b0, NO_EV},
        '{1'b1, 8'hA0, 1'b0, NO_EV},
        '{1'b0, 8'h85, 1'b0, NO_EV},
        '{1'b0, 8'hB3, 1'b0, NO_EV},
        '{1'b0, 8'h7A, 1'b0, NO_EV},
        '{1'b0, 8'h7F, 1'b0, NO_EV},
        '{1'b0, 8'h40, 1'b0, NO_EV},
        '{1'b1, 8'h80, 1'b0, NO_EV},
        '{1'b0, 8'h12, 1'b0, NO_EV},
        '{1'b1, 8'h80, 1'b0, NO_EV},
        '{1'b0, 8'h80, 1'b0, NO_EV},
        '{1'b0, 8'hF1, 1'b0, NO_EV},
        '{1'b0, 8'hFF, 1'b1, '{KIND_TIMECODE, 4'h0, 13'd0, 7'd7, 7'd15, 14'd0}},
        '{1'b0, 8'h80, 1'b0, NO_EV},
        '{1'b0, 8'hE0, 1'b0, NO_EV},
        '{1'b0, 8'h00, 1'b0, NO_EV},
        '{1'b0, 8'h00, 1'b0, NO_EV}
    };

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        push              = 1'b0;
    logic [7:0]  i_data_byte       = 8'h00;
    logic        i_start_of_packet = 1'b0;
    logic        pop               = 1'b0;
    logic        full;
    logic        empty;
    logic [4:0]  o_event_kind;
    logic [3:0]  o_channel;
    logic [12:0] o_timestamp;
    logic [6:0]  o_data_first;
    logic [6:0]  o_data_second;
    logic [13:0] o_wide_value;

    ble_midi_packet_parser_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_data_byte       (i_data_byte),
        .i_start_of_packet (i_start_of_packet),
        .empty             (empty),
        .pop               (pop),
        .o_event_kind      (o_event_kind),
        .o_channel         (o_channel),
        .o_timestamp       (o_timestamp),
        .o_data_first      (o_data_first),
        .o_data_second     (o_data_second),
        .o_wide_value      (o_wide_value)
    );

    always #5 i_clk = ~i_clk;

    // parser state mirror
    t_phase      ph      = PH_WAIT;
    logic        excl    = 1'b0;
    logic [5:0]  hdr_hi  = '0;
    logic [12:0] cur_ts  = '0;
    logic [7:0]  run_st  = '0;
    logic        run_ok  = 1'b0;
    logic [6:0]  held    = '0;
    logic        held_n  = 1'b0;

    t_midi_event pending_events [$];
    t_link_byte  link_q [$];
    int          errors  = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int          rx_hold = 0;

    task automatic report(input string msg);
        if (errors < PRINT_CAP)
            $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report($sformatf("%s got %0d, expected %0d", what, got, want));
    endtask

    function automatic t_midi_event mk(input logic [4:0] k, input logic [3:0] c,
                                       input logic [6:0] a, input logic [6:0] s,
                                       input logic [13:0] w);
        mk = '{k, c, cur_ts, a, s, w};
    endfunction

    function automatic bit chan_data(input logic [6:0] v, output t_midi_event ev);
        logic [3:0] ck;
        logic [3:0] ch;
        bit         hit;
        ck  = run_st[7:4];
        ch  = run_st[3:0];
        hit = 1'b1;
        ev  = '0;
        if (!held_n) begin
            if (ck == CK_PROG) begin
                ev = mk(KIND_PROG, ch, v, 7'd0, 14'd0);
            end else if (ck == CK_CHAN_PRES) begin
                ev = mk(KIND_CHAN_PRES, ch, 7'd0, v, 14'd0);
            end else begin
                held   = v;
                held_n = 1'b1;
                hit    = 1'b0;
            end
        end else begin
            held_n = 1'b0;
            case (ck)
                CK_NOTE_OFF: ev = mk(KIND_NOTE_OFF, ch, held, v, 14'd0);
                CK_NOTE_ON: begin
                    ev = mk((v == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON, ch, held, v, 14'd0);
                end
                CK_POLY: ev = mk(KIND_POLY, ch, held, v, 14'd0);
                CK_BEND: ev = mk(KIND_BEND, ch, 7'd0, 7'd0, {v, held});
                CK_CTRL: begin
                    if (held < CTL_MODE_FIRST) begin
                        ev = mk(KIND_CTRL, ch, held, v, 14'd0);
                    end else if (held == CTL_RESET_ALL) begin
                        ev = mk(KIND_MODE_BASE + 5'(held - CTL_MODE_FIRST), ch, held, v, 14'd0);
                    end else if (held == CTL_LOCAL) begin
                        if (v == 7'd0)
                            ev = mk(KIND_LOCAL, ch, held, 7'd0, 14'd0);
                        else if (v == DATA_MAX)
                            ev = mk(KIND_LOCAL, ch, held, 7'd1, 14'd0);
                        else
                            hit = 1'b0;
                    end else if (v == 7'd0) begin
                        ev = mk(KIND_MODE_BASE + 5'(held - CTL_MODE_FIRST), ch, held,
                                7'd0, 14'd0);
                    end else begin
                        hit = 1'b0;
                    end
                end
                default: hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

    function automatic bit parse_byte(input logic sop, input logic [7:0] b,
                                      output t_midi_event ev);
        logic [6:0] v;
        bit         hit;
        v   = b[6:0];
        hit = 1'b0;
        ev  = '0;
        if (sop) begin
            run_ok = 1'b0;
            held_n = 1'b0;
            if (b[7]) begin
                hdr_hi = b[5:0];
                ph     = PH_TS;
            end else begin
                ph = PH_WAIT;
            end
        end else if (ph == PH_WAIT) begin
            hit = 1'b0;
        end else if (excl) begin
            if (b == ST_SYSEX_END) begin
                excl = 1'b0;
                ph   = PH_TS;
            end else if (b[7]) begin
                cur_ts = {hdr_hi, v};
            end
        end else begin
            case (ph)
                PH_TS: begin
                    if (!b[7]) begin
                        ph = PH_WAIT;
                    end else begin
                        cur_ts = {hdr_hi, v};
                        ph     = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (b[7]) begin
                        held_n = 1'b0;
                        if (b < ST_SYSEX_START) begin
                            run_st = b;
                            run_ok = 1'b1;
                            ph     = PH_CHDATA;
                        end else begin
                            ph = PH_TS;
                            if (b < ST_CLOCK) begin
                                run_ok = 1'b0;
                                if (b == ST_SYSEX_START) begin
                                    excl = 1'b1;
                                end else if (b == ST_TIMECODE || b == ST_SONG_POS ||
                                             b == ST_SONG_SEL) begin
                                    run_st = b;
                                    ph     = PH_SYSDATA;
                                end else if (b == ST_TUNE_REQ) begin
                                    hit = 1'b1;
                                    ev  = mk(KIND_TUNE_REQ, 4'd0, 7'd0, 7'd0, 14'd0);
                                end
                            end else begin
                                hit = 1'b1;
                                case (b)
                                    ST_CLOCK:     ev = mk(KIND_CLOCK, 4'd0, 7'd0, 7'd0, 14'd0);
                                    ST_START:     ev = mk(KIND_START, 4'd0, 7'd0, 7'd0, 14'd0);
                                    ST_CONTINUE:  ev = mk(KIND_CONTINUE, 4'd0, 7'd0, 7'd0, 14'd0);
                                    ST_STOP:      ev = mk(KIND_STOP, 4'd0, 7'd0, 7'd0, 14'd0);
                                    ST_ACT_SENSE: ev = mk(KIND_ACT_SENSE, 4'd0, 7'd0, 7'd0, 14'd0);
                                    ST_RESET:     ev = mk(KIND_RESET, 4'd0, 7'd0, 7'd0, 14'd0);
                                    default:      hit = 1'b0;
                                endcase
                            end
                        end
                    end else if (!run_ok) begin
                        ph = PH_WAIT;
                    end else begin
                        ph     = PH_CHDATA;
                        held_n = 1'b0;
                        hit    = chan_data(v, ev);
                    end
                end
                PH_CHDATA: begin
                    if (!held_n && b[7]) begin
                        cur_ts = {hdr_hi, v};
                        ph     = PH_STATUS;
                    end else begin
                        hit = chan_data(v, ev);
                    end
                end
                default: begin
                    if (run_st == ST_SONG_POS) begin
                        if (!held_n) begin
                            held   = v;
                            held_n = 1'b1;
                        end else begin
                            held_n = 1'b0;
                            ph     = PH_TS;
                            hit    = 1'b1;
                            ev     = mk(KIND_SONG_POS, 4'd0, 7'd0, 7'd0, {v, held});
                        end
                    end else begin
                        ph = PH_TS;
                        if (run_st == ST_TIMECODE) begin
                            hit = 1'b1;
                            ev  = mk(KIND_TIMECODE, 4'd0, {4'd0, v[6:4]}, {3'd0, v[3:0]},
                                     14'd0);
                        end else if (run_st == ST_SONG_SEL) begin
                            hit = 1'b1;
                            ev  = mk(KIND_SONG_SEL, 4'd0, v, 7'd0, 14'd0);
                        end
                    end
                end
            endcase
        end
        return hit;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [7:0] data_byte(input int pct_high);
        return {($urandom_range(0, 99) < pct_high), 7'($urandom)};
    endfunction

    task automatic put(input logic sop, input logic [7:0] b);
        link_q.push_back('{sop, b});
    endtask

    task automatic gen_packet();
        int         n_msg;
        int         r;
        logic [7:0] st;
        logic [7:0] pkt_run;
        logic [6:0] first;
        logic [6:0] second;
        if ($urandom_range(0, 99) < 4) begin
            put(1'b1, 8'($urandom_range(0, 127)));
            repeat ($urandom_range(1, 4)) put(1'b0, 8'($urandom));
            return;
        end
        put(1'b1, 8'h80 | 8'($urandom_range(0, 127)));
        pkt_run = '0;
        n_msg   = $urandom_range(1, 6);
        for (int m = 0; m < n_msg; m++) begin
            if ($urandom_range(0, 99) < 5)
                put(1'b0, 8'($urandom));
            put(1'b0, 8'h80 | 8'($urandom_range(0, 127)));
            r = $urandom_range(0, 99);
            if (r < 45 || r >= 90) begin
                st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
                if (pkt_run[7] && $urandom_range(0, 3) == 0) begin
                    st = pkt_run;
                end else begin
                    put(1'b0, st);
                    pkt_run = st;
                end
                first = 7'($urandom);
                if (st[7:4] == CK_CTRL && $urandom_range(0, 1) == 1)
                    first = CTL_MODE_FIRST + 7'($urandom_range(0, 7));
                second = 7'($urandom);
                if (st[7:4] == CK_CTRL && $urandom_range(0, 2) != 0)
                    second = ($urandom_range(0, 1) == 1) ? DATA_MAX : 7'd0;
                if (st[7:4] == CK_NOTE_ON && $urandom_range(0, 4) == 0)
                    second = 7'd0;
                put(1'b0, {1'b0, first});
                if (r >= 90)
                    m = n_msg;
                else if (st[7:4] != CK_PROG && st[7:4] != CK_CHAN_PRES)
                    put(1'b0, {($urandom_range(0, 99) < 5), second});
            end else if (r < 60) begin
                pkt_run = '0;
                st = 8'($urandom_range(ST_TIMECODE, ST_SONG_SEL));
                put(1'b0, st);
                put(1'b0, data_byte(10));
                if (st == ST_SONG_POS)
                    put(1'b0, data_byte(10));
            end else if (r < 80) begin
                put(1'b0, 8'($urandom_range(8'hF4, 8'hFF)));
            end else begin
                pkt_run = '0;
                put(1'b0, ST_SYSEX_START);
                repeat ($urandom_range(0, 5)) put(1'b0, data_byte(25));
                if ($urandom_range(0, 9) < 7)
                    put(1'b0, ST_SYSEX_END);
            end
        end
    endtask

    task automatic send_byte(input logic sop, input logic [7:0] b, input logic typed,
                             input t_midi_event typed_ev);
        int          gap;
        bit          hit;
        t_midi_event ev;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push              <= 1'b1;
        i_data_byte       <= b;
        i_start_of_packet <= sop;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        hit = parse_byte(sop, b, ev);
        if (typed)
            pending_events.push_back(typed_ev);
        else if (hit)
            pending_events.push_back(ev);
    endtask

    // result side
    always @(posedge i_clk) begin : rx_side
        t_midi_event want;
        if (i_rst_n && pop && !empty) begin
            if (pending_events.size() == 0) begin
                report($sformatf("event kind %0d with none expected", o_event_kind));
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", o_event_kind, want.kind);
                check_field("channel", o_channel, want.chan);
                check_field("timestamp", o_timestamp, want.ts);
                check_field("data_first", o_data_first, want.d1);
                check_field("data_second", o_data_second, want.d2);
                check_field("wide_value", o_wide_value, want.wide);
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            rx_hold = pick_gap(rx_calm);
        end
        if ($urandom_range(0, 199) == 0)
            rx_calm = !rx_calm;
    end

    initial begin : tx_side
        t_link_byte lb;
        int         rnd_sent;
        rnd_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (DIR_TAB[i])
            send_byte(DIR_TAB[i].sop, DIR_TAB[i].b, DIR_TAB[i].typed, DIR_TAB[i].ev);
        while (rnd_sent < ITEMS) begin
            gen_packet();
            if ($urandom_range(0, 9) == 0)
                tx_calm = !tx_calm;
            while (link_q.size() != 0) begin
                lb = link_q.pop_front();
                send_byte(lb.sop, lb.b, 1'b0, NO_EV);
                rnd_sent++;
            end
        end
        push <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("tb_ble_midi_packet_parser_core: done, clean");
        else
            $display("tb_ble_midi_packet_parser_core: done, errors");
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("tb_ble_midi_packet_parser_core: done, errors");
        $finish;
    end

endmodule
